// File: sv/pgfu_pkg.sv
// Shared constants for the polar Gaussian unit: fixed-point formats of the
// logarithm, division and square-root chains. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pgfu_pkg;
  localparam int DEF_UNIFORM_BITS  = 32;
  localparam int DEF_OUT_FRAC_BITS = 27;
  localparam int OUT_W     = 32;
  localparam int T_FRAC    = 62;
  localparam int LOG_FRAC  = 56;
  localparam int W_FRAC    = 52;
  localparam int DIV_SHIFT = W_FRAC + T_FRAC - LOG_FRAC;
  localparam int DIV_STEPS = 128;
  localparam int SQ_PAIRS  = (64 + W_FRAC) / 2;
  localparam logic [63:0] LN2_Q64 = 64'hB172_17F7_D1CF_79AC;
endpackage
`default_nettype wire

// File: sv/pgfu_sq_cell.sv
// One cell of the logarithm chain: squares the mantissa and yields one
// fraction bit of log2, over two register stages. Depends on pgfu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pgfu_sq_cell import pgfu_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                v_i,
  input  wire logic [63:0]         y_i,
  input  wire logic [LOG_FRAC-1:0] frac_i,
  input  wire logic [SIDE_W-1:0]   side_i,
  output logic                     v_o,
  output logic [63:0]              y_o,
  output logic [LOG_FRAC-1:0]      frac_o,
  output logic [SIDE_W-1:0]        side_o
);
  logic                va_q, vb_q;
  logic [61:0]         hh_q;
  logic [62:0]         hl_q;
  logic [63:0]         ll_q;
  logic [LOG_FRAC-1:0] frac_a_q, frac_q;
  logic [SIDE_W-1:0]   side_a_q, side_q;
  logic [63:0]         y_q;
  logic [127:0]        sum;
  logic [63:0]         ys;
  logic [30:0]         yh;
  logic [31:0]         yl;

  assign yh  = y_i[62:32];
  assign yl  = y_i[31:0];
  assign sum = {2'b00, hh_q, 64'b0} + {32'b0, hl_q, 33'b0} + {64'b0, ll_q};
  assign ys  = sum[125:62];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= v_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hh_q     <= 62'(yh) * 62'(yh);
    hl_q     <= 63'(yh) * 63'(yl);
    ll_q     <= 64'(yl) * 64'(yl);
    frac_a_q <= frac_i;
    side_a_q <= side_i;
    y_q      <= ys[63] ? {1'b0, ys[63:1]} : ys;
    frac_q   <= {frac_a_q[LOG_FRAC-2:0], ys[63]};
    side_q   <= side_a_q;
  end

  assign v_o    = vb_q;
  assign y_o    = y_q;
  assign frac_o = frac_q;
  assign side_o = side_q;
endmodule
`default_nettype wire

// File: sv/pgfu_mul64.sv
// Two-stage 64 by 64 unsigned multiplier built from four 32 by 32-bit partial
// products, carrying a side word alongside. Depends on pgfu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pgfu_mul64 import pgfu_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              v_i,
  input  wire logic [63:0]       a_i,
  input  wire logic [63:0]       b_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   v_o,
  output logic [127:0]           p_o,
  output logic [SIDE_W-1:0]      side_o
);
  logic              va_q, vb_q;
  logic [63:0]       hh_q, hl_q, lh_q, ll_q;
  logic [SIDE_W-1:0] side_a_q, side_q;
  logic [127:0]      p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= v_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hh_q     <= 64'(a_i[63:32]) * 64'(b_i[63:32]);
    hl_q     <= 64'(a_i[63:32]) * 64'(b_i[31:0]);
    lh_q     <= 64'(a_i[31:0]) * 64'(b_i[63:32]);
    ll_q     <= 64'(a_i[31:0]) * 64'(b_i[31:0]);
    side_a_q <= side_i;
    p_q      <= {hh_q, 64'b0} + {32'b0, hl_q, 32'b0} + {32'b0, lh_q, 32'b0}
                + {64'b0, ll_q};
    side_q   <= side_a_q;
  end

  assign v_o    = vb_q;
  assign p_o    = p_q;
  assign side_o = side_q;
endmodule
`default_nettype wire

// File: sv/pgfu_div_cell.sv
// One cell of the restoring divider: one quotient bit per cell.
// Depends on pgfu_pkg for the dividend alignment.
`timescale 1ns / 1ps
`default_nettype none
module pgfu_div_cell import pgfu_pkg::*; #(
  parameter int NUM_IDX = 0,
  parameter int SIDE_W  = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              v_i,
  input  wire logic [63:0]       a_i,
  input  wire logic [63:0]       d_i,
  input  wire logic [63:0]       rem_i,
  input  wire logic [63:0]       q_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   v_o,
  output logic [63:0]            a_o,
  output logic [63:0]            d_o,
  output logic [63:0]            rem_o,
  output logic [63:0]            q_o,
  output logic [SIDE_W-1:0]      side_o
);
  logic              v_q;
  logic [63:0]       a_q, d_q, rem_q, q_q;
  logic [SIDE_W-1:0] side_q;
  logic              nbit, ge;
  logic [64:0]       r2, diff;

  if (NUM_IDX >= DIV_SHIFT && NUM_IDX - DIV_SHIFT < 64) begin : g_bit
    assign nbit = a_i[NUM_IDX-DIV_SHIFT];
  end else begin : g_zero
    assign nbit = 1'b0;
  end

  assign r2   = {rem_i, nbit};
  assign diff = r2 - {1'b0, d_i};
  assign ge   = (r2 >= {1'b0, d_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_i;
    d_q    <= d_i;
    rem_q  <= ge ? diff[63:0] : r2[63:0];
    q_q    <= {q_i[62:0], ge};
    side_q <= side_i;
  end

  assign v_o    = v_q;
  assign a_o    = a_q;
  assign d_o    = d_q;
  assign rem_o  = rem_q;
  assign q_o    = q_q;
  assign side_o = side_q;
endmodule
`default_nettype wire

// File: sv/pgfu_sqrt_cell.sv
// One cell of the digit-by-digit square root: one root bit per cell from
// one pair of radicand bits. Depends on pgfu_pkg for the radicand alignment.
`timescale 1ns / 1ps
`default_nettype none
module pgfu_sqrt_cell import pgfu_pkg::*; #(
  parameter int PAIR_IDX = 0,
  parameter int SIDE_W   = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              v_i,
  input  wire logic [63:0]       w_i,
  input  wire logic [63:0]       rem_i,
  input  wire logic [63:0]       root_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   v_o,
  output logic [63:0]            w_o,
  output logic [63:0]            rem_o,
  output logic [63:0]            root_o,
  output logic [SIDE_W-1:0]      side_o
);
  localparam int BHI = 2 * PAIR_IDX + 1;
  localparam int BLO = 2 * PAIR_IDX;

  logic              v_q;
  logic [63:0]       w_q, rem_q, root_q;
  logic [SIDE_W-1:0] side_q;
  logic              bhi, blo, ge;
  logic [65:0]       cur, trial;

  if (BHI >= W_FRAC) begin : g_hi
    assign bhi = w_i[BHI-W_FRAC];
  end else begin : g_hi_zero
    assign bhi = 1'b0;
  end
  if (BLO >= W_FRAC) begin : g_lo
    assign blo = w_i[BLO-W_FRAC];
  end else begin : g_lo_zero
    assign blo = 1'b0;
  end

  assign cur   = {rem_i, bhi, blo};
  assign trial = {root_i, 2'b01};
  assign ge    = (cur >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q    <= w_i;
    rem_q  <= ge ? 64'(cur - trial) : 64'(cur);
    root_q <= {root_i[62:0], ge};
    side_q <= side_i;
  end

  assign v_o    = v_q;
  assign w_o    = w_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign side_o = side_q;
endmodule
`default_nettype wire

// File: sv/polar_gaussian_from_uniforms_unit.sv
// Top level of the polar Gaussian unit: input stages, logarithm, divider and
// square-root cell chains, output scaling. Depends on pgfu_pkg and all cells.
//
//   channel   signals                                        direction
//   command   start, busy (out), uniform_first_i, uniform_second_i  in
//   result    done_o, normal_first_o, normal_second_o         out
//
// A transaction is taken in every cycle in which start is high; busy never rises.
// The pipeline holds 3 input stages, 56 squaring cells, the logarithm scaling
// multiplier, 128 divider cells, 58 square-root cells, the output
// multipliers and the output register.
// A rejected pair travels the chain as a bubble and raises no done_o.
// Reset clears only the valid bits of the chain.
`timescale 1ns / 1ps
`default_nettype none
module polar_gaussian_from_uniforms_unit import pgfu_pkg::*; #(
  parameter int UNIFORM_BITS  = DEF_UNIFORM_BITS,
  parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [UNIFORM_BITS-1:0] uniform_first_i,
  input  wire logic [UNIFORM_BITS-1:0] uniform_second_i,
  output logic                         done_o,
  output logic signed [OUT_W-1:0]      normal_first_o,
  output logic signed [OUT_W-1:0]      normal_second_o
);
  localparam int U          = UNIFORM_BITS;
  localparam int H          = U - 1;
  localparam int S_FRAC     = 2 * H;
  localparam int SW         = 2 * U + 1;
  localparam int KW         = $clog2(S_FRAC);
  localparam int BASE_W     = 2 + 2 * U + KW;
  localparam int LOG_SIDE_W = 1 + 64 + BASE_W;
  localparam int LN_SIDE_W  = 64 + BASE_W;
  localparam int SH_L       = (S_FRAC >= T_FRAC) ? 0 : T_FRAC - S_FRAC;
  localparam int SH_R       = (S_FRAC >= T_FRAC) ? S_FRAC - T_FRAC : 0;
  localparam int OUT_SH     = H + W_FRAC - OUT_FRAC_BITS;
  localparam logic [U-1:0] HALF = U'(1) << H;

  function automatic logic [OUT_W-1:0] round_sat(input logic [127:0] p, input logic neg);
    logic [127:0]     r;
    logic [OUT_W-1:0] lim, v;
    r   = (p + (128'd1 << (OUT_SH - 1))) >> OUT_SH;
    lim = neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    v   = (r > 128'(lim)) ? lim : r[OUT_W-1:0];
    return neg ? OUT_W'(-v) : v;
  endfunction

  // Input stages.
  logic              n1, n2;
  logic [U-1:0]      m1, m2;
  logic [2*U-1:0]    sq1, sq2;
  logic              p0_v_q, p0_n1_q, p0_n2_q;
  logic [U-1:0]      p0_m1_q, p0_m2_q;
  logic [SW-1:0]     p0_s_q;
  logic              ok;
  logic [KW-1:0]     k_d;
  logic              p1_v_q, p1_n1_q, p1_n2_q;
  logic [U-1:0]      p1_m1_q, p1_m2_q;
  logic [KW-1:0]     p1_k_q;
  logic [S_FRAC-1:0] p1_s_q;
  logic [127:0]      sn;
  logic              p2_v_q;
  logic [63:0]       p2_t_q;
  logic [BASE_W-1:0] p2_base_q;

  assign n1  = uniform_first_i < HALF;
  assign n2  = uniform_second_i < HALF;
  assign m1  = n1 ? HALF - uniform_first_i : uniform_first_i - HALF;
  assign m2  = n2 ? HALF - uniform_second_i : uniform_second_i - HALF;
  assign sq1 = (2*U)'(m1) * (2*U)'(m1);
  assign sq2 = (2*U)'(m2) * (2*U)'(m2);

  assign ok = (p0_s_q != '0) && (p0_s_q[SW-1:S_FRAC] == '0);

  always_comb begin
    k_d = '0;
    for (int p = 0; p < H; p++) begin
      if (p0_s_q[2*p +: 2] != 2'b00) begin
        k_d = KW'(2 * (H - 1 - p));
      end
    end
  end

  assign sn = ((128'(p1_s_q) << p1_k_q) << SH_L) >> SH_R;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_v_q <= 1'b0;
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
    end else begin
      p0_v_q <= start & ~busy;
      p1_v_q <= p0_v_q & ok;
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p0_n1_q   <= n1;
    p0_n2_q   <= n2;
    p0_m1_q   <= m1;
    p0_m2_q   <= m2;
    p0_s_q    <= SW'(sq1) + SW'(sq2);
    p1_n1_q   <= p0_n1_q;
    p1_n2_q   <= p0_n2_q;
    p1_m1_q   <= p0_m1_q;
    p1_m2_q   <= p0_m2_q;
    p1_k_q    <= k_d;
    p1_s_q    <= p0_s_q[S_FRAC-1:0];
    p2_t_q    <= sn[63:0];
    p2_base_q <= {p1_n1_q, p1_n2_q, p1_m1_q, p1_m2_q, p1_k_q};
  end

  // Logarithm chain.
  logic [63:0]         y0;
  logic                ip0;
  logic                lg_v    [LOG_FRAC+1];
  logic [63:0]         lg_y    [LOG_FRAC+1];
  logic [LOG_FRAC-1:0] lg_frac [LOG_FRAC+1];
  logic [LOG_SIDE_W-1:0] lg_side [LOG_FRAC+1];

  assign y0          = {p2_t_q[61:0], 2'b00};
  assign ip0         = y0[63];
  assign lg_v[0]     = p2_v_q;
  assign lg_y[0]     = ip0 ? {1'b0, y0[63:1]} : y0;
  assign lg_frac[0]  = '0;
  assign lg_side[0]  = {ip0, p2_t_q, p2_base_q};

  for (genvar i = 0; i < LOG_FRAC; i++) begin : g_log
    pgfu_sq_cell #(.SIDE_W(LOG_SIDE_W)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .v_i    (lg_v[i]),
      .y_i    (lg_y[i]),
      .frac_i (lg_frac[i]),
      .side_i (lg_side[i]),
      .v_o    (lg_v[i+1]),
      .y_o    (lg_y[i+1]),
      .frac_o (lg_frac[i+1]),
      .side_o (lg_side[i+1])
    );
  end

  // Scaling by 2 ln 2.
  logic                  le_ip;
  logic [63:0]           le_t;
  logic [BASE_W-1:0]     le_base;
  logic [63:0]           lval;
  logic                  ln_v;
  logic [127:0]          ln_p;
  logic [LN_SIDE_W-1:0]  ln_side;

  assign le_ip   = lg_side[LOG_FRAC][LOG_SIDE_W-1];
  assign le_t    = lg_side[LOG_FRAC][LOG_SIDE_W-2 -: 64];
  assign le_base = lg_side[LOG_FRAC][BASE_W-1:0];
  assign lval    = ((64'(le_base[KW-1:0]) + 64'd2 - 64'(le_ip)) << LOG_FRAC)
                   - 64'(lg_frac[LOG_FRAC]);

  pgfu_mul64 #(.SIDE_W(LN_SIDE_W)) u_ln (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .v_i    (lg_v[LOG_FRAC]),
    .a_i    (lval),
    .b_i    (LN2_Q64),
    .side_i ({le_t, le_base}),
    .v_o    (ln_v),
    .p_o    (ln_p),
    .side_o (ln_side)
  );

  // Division chain.
  logic              dv_v    [DIV_STEPS+1];
  logic [63:0]       dv_a    [DIV_STEPS+1];
  logic [63:0]       dv_d    [DIV_STEPS+1];
  logic [63:0]       dv_rem  [DIV_STEPS+1];
  logic [63:0]       dv_q    [DIV_STEPS+1];
  logic [BASE_W-1:0] dv_side [DIV_STEPS+1];

  assign dv_v[0]    = ln_v;
  assign dv_a[0]    = ln_p[126:63];
  assign dv_d[0]    = ln_side[LN_SIDE_W-1 -: 64];
  assign dv_rem[0]  = '0;
  assign dv_q[0]    = '0;
  assign dv_side[0] = ln_side[BASE_W-1:0];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    pgfu_div_cell #(.NUM_IDX(DIV_STEPS - 1 - i), .SIDE_W(BASE_W)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .v_i    (dv_v[i]),
      .a_i    (dv_a[i]),
      .d_i    (dv_d[i]),
      .rem_i  (dv_rem[i]),
      .q_i    (dv_q[i]),
      .side_i (dv_side[i]),
      .v_o    (dv_v[i+1]),
      .a_o    (dv_a[i+1]),
      .d_o    (dv_d[i+1]),
      .rem_o  (dv_rem[i+1]),
      .q_o    (dv_q[i+1]),
      .side_o (dv_side[i+1])
    );
  end

  // Square-root chain.
  logic              sr_v    [SQ_PAIRS+1];
  logic [63:0]       sr_w    [SQ_PAIRS+1];
  logic [63:0]       sr_rem  [SQ_PAIRS+1];
  logic [63:0]       sr_root [SQ_PAIRS+1];
  logic [BASE_W-1:0] sr_side [SQ_PAIRS+1];

  assign sr_v[0]    = dv_v[DIV_STEPS];
  assign sr_w[0]    = dv_q[DIV_STEPS];
  assign sr_rem[0]  = '0;
  assign sr_root[0] = '0;
  assign sr_side[0] = dv_side[DIV_STEPS];

  for (genvar i = 0; i < SQ_PAIRS; i++) begin : g_sqrt
    pgfu_sqrt_cell #(.PAIR_IDX(SQ_PAIRS - 1 - i), .SIDE_W(BASE_W)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .v_i    (sr_v[i]),
      .w_i    (sr_w[i]),
      .rem_i  (sr_rem[i]),
      .root_i (sr_root[i]),
      .side_i (sr_side[i]),
      .v_o    (sr_v[i+1]),
      .w_o    (sr_w[i+1]),
      .rem_o  (sr_rem[i+1]),
      .root_o (sr_root[i+1]),
      .side_o (sr_side[i+1])
    );
  end

  // Output scaling.
  logic [BASE_W-1:0] fb;
  logic [KW-1:0]     fk;
  logic [63:0]       mag1, mag2;
  logic              o1_v, o2_v, o1_n, o2_n;
  logic [127:0]      o1_p, o2_p;
  logic              done_q;
  logic [OUT_W-1:0]  nf1_q, nf2_q;

  assign fb   = sr_side[SQ_PAIRS];
  assign fk   = fb[KW-1:0];
  assign mag1 = 64'(fb[BASE_W-3 -: U]) << fk[KW-1:1];
  assign mag2 = 64'(fb[BASE_W-3-U -: U]) << fk[KW-1:1];

  pgfu_mul64 #(.SIDE_W(1)) u_out1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .v_i    (sr_v[SQ_PAIRS]),
    .a_i    (mag1),
    .b_i    (sr_root[SQ_PAIRS]),
    .side_i (fb[BASE_W-1]),
    .v_o    (o1_v),
    .p_o    (o1_p),
    .side_o (o1_n)
  );

  pgfu_mul64 #(.SIDE_W(1)) u_out2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .v_i    (sr_v[SQ_PAIRS]),
    .a_i    (mag2),
    .b_i    (sr_root[SQ_PAIRS]),
    .side_i (fb[BASE_W-2]),
    .v_o    (o2_v),
    .p_o    (o2_p),
    .side_o (o2_n)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= o1_v & o2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    nf1_q <= round_sat(o1_p, o1_n);
    nf2_q <= round_sat(o2_p, o2_n);
  end

  assign busy            = 1'b0;
  assign done_o          = done_q;
  assign normal_first_o  = nf1_q;
  assign normal_second_o = nf2_q;
endmodule
`default_nettype wire

// File: tb/polar_gaussian_from_uniforms_unit_tb.sv
// Self-checking testbench for the polar Gaussian unit: drives uniform pairs,
// predicts the rejection test and both normal variates in fixed point, and
// compares every result. Depends on pgfu_pkg and polar_gaussian_from_uniforms_unit.
`timescale 1ns / 1ps
module polar_gaussian_from_uniforms_unit_tb;
  import pgfu_pkg::*;

  localparam int UB       = DEF_UNIFORM_BITS;
  localparam int OFB      = DEF_OUT_FRAC_BITS;
  localparam int HB       = UB - 1;
  localparam int S_FRAC   = 2 * HB;
  localparam int OUT_SH   = HB + W_FRAC - OFB;
  localparam int N_RANDOM = 430;
  localparam int LATENCY  = 306;
  localparam int WDOG_MAX = 4000;

  typedef struct {
    logic            drain;
    logic [UB-1:0]   a;
    logic [UB-1:0]   b;
  } pair_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [UB-1:0] uniform_first_i = '0;
  logic [UB-1:0] uniform_second_i = '0;
  logic done_o;
  logic signed [OUT_W-1:0] normal_first_o;
  logic signed [OUT_W-1:0] normal_second_o;

  pair_t pending_pairs[$];
  logic signed [OUT_W-1:0] normals_first_q[$];
  logic signed [OUT_W-1:0] normals_second_q[$];
  int accepted_pairs = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  polar_gaussian_from_uniforms_unit u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .uniform_first_i(uniform_first_i), .uniform_second_i(uniform_second_i),
    .done_o(done_o), .normal_first_o(normal_first_o), .normal_second_o(normal_second_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [OUT_W-1:0] scale_normal(logic [127:0] mag, logic neg,
                                                    logic [127:0] mult);
    logic [127:0] p;
    logic [63:0] lim, v;
    p = (mag * mult + (128'd1 << (OUT_SH - 1))) >> OUT_SH;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    v = (p > {64'd0, lim}) ? lim : p[63:0];
    if (neg) v = 64'd0 - v;
    return v[OUT_W-1:0];
  endfunction

  // Returns 1 when the pair lies strictly inside the unit circle (and not at its centre).
  function automatic logic polar_normals(logic [UB-1:0] r1, logic [UB-1:0] r2,
                                         output logic [OUT_W-1:0] g1,
                                         output logic [OUT_W-1:0] g2);
    logic [127:0] half, m1, m2, s, p, num, mult, cand, yv;
    logic n1, n2;
    int k, ip;
    logic [63:0] t, y, frac, lval, a, w;
    half = 128'd1 << HB;
    n1 = r1 < half;
    n2 = r2 < half;
    m1 = n1 ? half - r1 : r1 - half;
    m2 = n2 ? half - r2 : r2 - half;
    s = m1 * m1 + m2 * m2;
    g1 = '0;
    g2 = '0;
    if (s == 0 || s >= (128'd1 << S_FRAC)) return 1'b0;
    k = 0;
    while (s < (128'd1 << (S_FRAC - 2)) && k < S_FRAC) begin
      s = s << 2;
      k += 2;
    end
    t = 64'(s >> (S_FRAC - T_FRAC));
    y = t << 2;
    ip = 0;
    if (y[63]) begin
      ip = 1;
      y = y >> 1;
    end
    frac = '0;
    for (int i = 0; i < LOG_FRAC; i++) begin
      yv = {64'd0, y};
      p = yv * yv;
      y = p[125:62];
      frac = frac << 1;
      if (y[63]) begin
        frac[0] = 1'b1;
        y = y >> 1;
      end
    end
    lval = (64'(k + 2 - ip) << LOG_FRAC) - frac;
    p = {64'd0, lval} * {64'd0, LN2_Q64};
    a = p[126:63];
    num = {64'd0, a} << DIV_SHIFT;
    w = 64'(num / {64'd0, t});
    num = {64'd0, w} << W_FRAC;
    mult = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = mult | (128'd1 << b);
      if (cand * cand <= num) mult = cand;
    end
    g1 = scale_normal(m1 << (k / 2), n1, mult);
    g2 = scale_normal(m2 << (k / 2), n2, mult);
    return 1'b1;
  endfunction

  function automatic int idle_percent(int n);
    if (n < 150) return 24;
    if (n < 300) return 80;
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [OUT_W-1:0] g1, g2;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (polar_normals(uniform_first_i, uniform_second_i, g1, g2)) begin
          normals_first_q.push_back(g1);
          normals_second_q.push_back(g2);
        end
        accepted_pairs++;
      end
      if (!start || !busy) begin
        if (pending_pairs.size() == 0) begin
          start <= 1'b0;
        end else if (pending_pairs[0].drain) begin
          start <= 1'b0;
          if (normals_first_q.size() == 0) void'(pending_pairs.pop_front());
        end else if ($urandom_range(99) < idle_percent(accepted_pairs)) begin
          start <= 1'b0;
        end else begin
          start <= 1'b1;
          uniform_first_i <= pending_pairs[0].a;
          uniform_second_i <= pending_pairs[0].b;
          void'(pending_pairs.pop_front());
        end
      end
    end
  end

  always @(posedge clk_i) begin
    logic [OUT_W-1:0] e1, e2;
    if (rst_ni && done_o) begin
      if (normals_first_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: %h %h", normal_first_o,
                                       normal_second_o);
      end else begin
        e1 = normals_first_q.pop_front();
        e2 = normals_second_q.pop_front();
        if (e1 !== normal_first_o || e2 !== normal_second_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %h %h, got %h %h", e1, e2,
                     normal_first_o, normal_second_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic add_pair(logic [UB-1:0] a, logic [UB-1:0] b);
    pair_t it;
    it.drain = 1'b0;
    it.a = a;
    it.b = b;
    pending_pairs.push_back(it);
  endtask

  task automatic add_drain();
    pair_t it;
    it.drain = 1'b1;
    it.a = '0;
    it.b = '0;
    pending_pairs.push_back(it);
  endtask

  initial begin
    logic [UB-1:0] centre;
    centre = 1 << HB;
    // Corners and centre are rejected; most of the rest probe the edges of acceptance.
    add_pair('0, '0);
    add_pair(centre, centre);
    add_pair('1, '1);
    add_pair('0, centre);
    add_pair(centre, '0);
    add_pair('1, centre);
    add_pair(centre, '1);
    add_pair(centre + 1, centre);
    add_pair(centre, centre - 1);
    add_pair(centre + 1, centre + 1);
    add_pair(centre - 1, centre - 1);
    add_pair(centre + 1, centre - 1);
    add_pair(centre + 255, centre - 4096);
    add_pair(32'hB504_F333, 32'hB504_F333);
    add_pair(32'h4AFB_0CCD, 32'h4AFB_0CCD);
    add_pair(32'hC000_0000, 32'h4000_0000);
    add_pair(32'h0000_0001, centre);
    add_pair(centre, 32'h0000_0001);
    add_pair(32'hAAAA_AAAA, 32'h5555_5555);
    add_pair(32'h5555_5555, 32'hAAAA_AAAA);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) add_drain();
      if ($urandom_range(9) < 2)
        add_pair(centre + $urandom_range(2047) - 1024,
                 centre - ($urandom >> $urandom_range(31)));
      else
        add_pair($urandom, $urandom);
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_pairs.size() == 0);
    @(posedge clk_i);
    wait (!start);
    wait (normals_first_q.size() == 0);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (mismatches == 0 && normals_first_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// File: sim.f
sv/pgfu_pkg.sv
sv/pgfu_sq_cell.sv
sv/pgfu_mul64.sv
sv/pgfu_div_cell.sv
sv/pgfu_sqrt_cell.sv
sv/polar_gaussian_from_uniforms_unit.sv
tb/polar_gaussian_from_uniforms_unit_tb.sv
